// ===== rtl/slw_pkg.sv =====
// Shared types, constants and helper functions for the servo slew ramp block.
package slw_pkg;

  localparam int CHANNEL_COUNT = 6;
  localparam int CH_AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  localparam int POS_W = 12;
  localparam int DIV_N_W = 21;
  localparam int CFG_AW = 4;

  localparam logic [15:0] US_MIN = 16'd800;
  localparam logic [15:0] US_MAX = 16'd2400;
  localparam int US_RANGE = 2400 - 800;
  localparam int PWM_FULL = 4095;
  localparam int FRAMES_PER_S = 50;
  localparam logic [POS_W-1:0] MID_PWM = 12'd1791;
  localparam logic [POS_W-1:0] SPEED_RESET = 12'd10;

  // us path: (d*4095) >> 6, then /25 ; speed path: (x*4095) >> 7, then /625
  localparam int US_PRESHIFT = 6;
  localparam int SPEED_PRESHIFT = 7;
  localparam int US_DIV = US_RANGE / (1 << US_PRESHIFT);
  localparam int SPEED_DIV = US_RANGE * FRAMES_PER_S / (1 << SPEED_PRESHIFT);

  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_W = 27;
  localparam int PROD_W = DIV_N_W + RECIP_W;
  localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] US_RECIP = RECIP_W'(RECIP_ONE / US_DIV);
  localparam logic [RECIP_W-1:0] SPEED_RECIP = RECIP_W'(RECIP_ONE / SPEED_DIV);
  localparam logic [DIV_N_W-1:0] US_DIV_N = DIV_N_W'(US_DIV);
  localparam logic [DIV_N_W-1:0] SPEED_DIV_N = DIV_N_W'(SPEED_DIV);

  localparam logic KIND_DRIVE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    FN_TICK   = 3'd0,
    FN_SELECT = 3'd1,
    FN_SET_US = 3'd2,
    FN_CONFIG = 3'd3,
    FN_TOGGLE = 3'd4,
    FN_QUERY  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    REG_SERVO_OFF  = 2'd0,
    REG_SOFT_START = 2'd1,
    REG_DEADBAND   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    TAG_A     = 2'd0,
    TAG_B     = 2'd1,
    TAG_SPEED = 2'd2
  } div_tag_t;

  typedef enum logic {
    DIV_US    = 1'b0,
    DIV_SPEED = 1'b1
  } div_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DIV,
    ST_DWAIT,
    ST_MOD
  } state_t;

  typedef struct packed {
    logic        servo_off;
    logic        soft_start;
    logic [15:0] deadband;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] end_a;
    logic [POS_W-1:0] end_b;
    logic [POS_W-1:0] speed;
    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] tgt;
    logic [POS_W-1:0] ss_step;
  } chan_t;

  localparam chan_t CHAN_RESET = '{
    end_a: MID_PWM, end_b: MID_PWM, speed: SPEED_RESET,
    cur: MID_PWM, tgt: MID_PWM, ss_step: 12'd1
  };

  typedef struct packed {
    logic             rd_en;
    logic [CH_AW-1:0] rd_addr;
    logic             wr_en;
    logic [CH_AW-1:0] wr_addr;
    chan_t            wr_data;
  } mem_req_t;

  typedef struct packed {
    logic               valid;
    div_tag_t           tag;
    div_mode_t          mode;
    logic [DIV_N_W-1:0] n;
  } div_req_t;

  typedef struct packed {
    logic             valid;
    div_tag_t         tag;
    logic [POS_W-1:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  servo_index;
    logic        use_position_a;
    logic [15:0] pulse_us;
    logic [15:0] pos_a_us;
    logic [15:0] pos_b_us;
    logic [15:0] slew_rate_us;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [3:0]       channel;
    logic [POS_W-1:0] pwm_value;
    logic [POS_W-1:0] current_pos;
    logic [POS_W-1:0] target_pos;
    logic             moving;
    logic             index_valid;
    logic             last;
  } out_item_t;

  // Clamp to the pulse range and prescale; the divider finishes with /US_DIV.
  function automatic logic [DIV_N_W-1:0] us_to_n(input logic [15:0] us);
    logic [15:0] v;
    logic [22:0] d;
    logic [22:0] p;
    v = us;
    if (v < US_MIN) v = US_MIN;
    if (v > US_MAX) v = US_MAX;
    d = 23'(v - US_MIN);
    p = (d << 12) - d;
    return DIV_N_W'(p >> US_PRESHIFT);
  endfunction

  function automatic logic [DIV_N_W-1:0] speed_to_n(input logic [15:0] us);
    logic [27:0] x;
    logic [27:0] p;
    x = 28'(us);
    p = (x << 12) - x;
    return DIV_N_W'(p >> SPEED_PRESHIFT);
  endfunction

endpackage

// ===== rtl/slw_in_if.sv =====
// Input command channel: valid/ready with one command payload.
interface slw_in_if import slw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/slw_out_if.sv =====
// Result channel: valid/ready with one drive or status payload.
interface slw_out_if import slw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/slw_regs.sv =====
// APB-style configuration registers.
module slw_regs import slw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[3:2]);
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.servo_off <= 1'b1;
      cfg_r.soft_start <= 1'b1;
      cfg_r.deadband <= 16'd3;
    end else if (wr) begin
      case (idx)
        REG_SERVO_OFF:  cfg_r.servo_off <= pwdata[0];
        REG_SOFT_START: cfg_r.soft_start <= pwdata[0];
        REG_DEADBAND:   cfg_r.deadband <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SERVO_OFF:  prdata = {31'd0, cfg_r.servo_off};
      REG_SOFT_START: prdata = {31'd0, cfg_r.soft_start};
      REG_DEADBAND:   prdata = {16'd0, cfg_r.deadband};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/slw_chan_mem.sv =====
// Per-channel state memory, one word per channel, registered read.
module slw_chan_mem import slw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output chan_t    rd_word
);

  chan_t                    mem [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] vld_r;
  chan_t                    rd_word_r;

  assign rd_word = rd_word_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // entries never written read back as their reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_word_r <= vld_r[req.rd_addr] ? mem[req.rd_addr] : CHAN_RESET;
    end
  end

endmodule

// ===== rtl/slw_cdiv.sv =====
// Two-stage divide by a constant: reciprocal multiply, then one-step correction.
module slw_cdiv import slw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               v1_r;
  div_tag_t           tag1_r;
  div_mode_t          mode1_r;
  logic [DIV_N_W-1:0] n1_r;
  logic [PROD_W-1:0]  prod_r;
  logic [RECIP_W-1:0] recip;

  logic [POS_W-1:0]   q_est;
  logic [DIV_N_W-1:0] dsr;
  logic [DIV_N_W-1:0] qd;
  logic [DIV_N_W-1:0] rem;
  logic [POS_W-1:0]   q;

  logic               v2_r;
  div_tag_t           tag2_r;
  logic [POS_W-1:0]   q2_r;

  assign recip = (req.mode == DIV_US) ? US_RECIP : SPEED_RECIP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r <= req.tag;
    mode1_r <= req.mode;
    n1_r <= req.n;
    prod_r <= PROD_W'(req.n) * PROD_W'(recip);
    tag2_r <= tag1_r;
    q2_r <= q;
  end

  // estimate is the true quotient or one below it
  always_comb begin
    q_est = prod_r[RECIP_SHIFT +: POS_W];
    dsr = (mode1_r == DIV_US) ? US_DIV_N : SPEED_DIV_N;
    qd = DIV_N_W'(q_est) * dsr;
    rem = n1_r - qd;
    q = (rem >= dsr) ? q_est + 12'd1 : q_est;
  end

  assign rsp.valid = v2_r;
  assign rsp.tag = tag2_r;
  assign rsp.q = q2_r;

endmodule

// ===== rtl/multi_servo_slew_ramp_core.sv =====
// Top level of the multi-channel servo slew ramp with soft start.
//
//  port     | dir     | protocol          | carries
//  ---------+---------+-------------------+-------------------------------------
//  in_ch    | sink    | valid/ready       | command or tick transaction
//  out_ch   | source  | valid/ready       | drive item (per channel) or status
//  p*       | slave   | APB-style, 32 bit | servo_off, soft_start, deadband
//
// Tick: one memory read-modify-write per channel, with the next channel's read
//   overlapped with the current write.
// Set target and configure go through the divider (ops issued one per cycle into
//   the two-stage constant divider); select, toggle, query and invalid index do not.
// Reset (synchronous, rst_n low) clears control and the per-entry valid bits.
// A full output register stalls the sequencer; input is taken only when idle.
module multi_servo_slew_ramp_core import slw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  slw_in_if.sink            in_ch,
  slw_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg;
  mem_req_t   mem_req;
  chan_t      rd_word;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  state_t     state_r, state_nxt;
  in_item_t   item_r;
  logic       idx_ok_r;
  logic [CH_AW-1:0] ch_r;
  div_tag_t   k_r;
  logic [POS_W-1:0] q_a_r, q_b_r, q_sp_r;
  out_item_t  out_item_r, out_nxt;
  logic       out_valid_r;

  logic       in_acc, idx_ok_in, is_tick_in;
  logic       out_free, out_load, ch_last, ch_adv, k_adv;
  div_tag_t   last_tag;

  // tick datapath
  logic [POS_W-1:0] gap, soft_new, step, tick_cur, tick_drive;
  logic             arrived;
  chan_t            tick_word;

  // command datapath
  logic [POS_W:0]   mid_sum;
  logic [POS_W-1:0] mid;
  chan_t            cmd_word;
  logic             cmd_wr;

  slw_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  slw_chan_mem u_mem (.clk, .rst_n, .req(mem_req), .rd_word);

  slw_cdiv u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  assign in_ch.ready = (state_r == ST_IDLE) && rst_n;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign idx_ok_in = {1'b0, in_ch.data.servo_index} < 5'(CHANNEL_COUNT);
  assign is_tick_in = (in_ch.data.func == FN_TICK);

  assign out_free = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_item_r;

  assign ch_last = (ch_r == CH_AW'(CHANNEL_COUNT - 1));
  assign last_tag = (item_r.func == FN_SET_US) ? TAG_A : TAG_SPEED;

  always_comb begin
    gap = (rd_word.cur > rd_word.tgt) ? rd_word.cur - rd_word.tgt
                                      : rd_word.tgt - rd_word.cur;
    arrived = {4'd0, gap} <= cfg.deadband;
    soft_new = (cfg.soft_start && (rd_word.ss_step < rd_word.speed))
               ? rd_word.ss_step + 12'd1 : rd_word.ss_step;
    step = cfg.soft_start ? soft_new : rd_word.speed;
    tick_word = rd_word;
    if (arrived) begin
      tick_cur = rd_word.tgt;
      tick_drive = cfg.servo_off ? '0 : rd_word.tgt;
    end else begin
      tick_word.ss_step = soft_new;
      if (gap <= step) tick_cur = rd_word.tgt;
      else if (rd_word.cur < rd_word.tgt) tick_cur = rd_word.cur + step;
      else tick_cur = rd_word.cur - step;
      tick_drive = tick_cur;
    end
    tick_word.cur = tick_cur;
  end

  always_comb begin
    mid_sum = {1'b0, rd_word.end_a} + {1'b0, rd_word.end_b};
    mid = mid_sum[POS_W:1];
    cmd_word = rd_word;
    cmd_wr = idx_ok_r;
    case (item_r.func)
      FN_SELECT: begin
        cmd_word.tgt = item_r.use_position_a ? rd_word.end_a : rd_word.end_b;
        cmd_word.ss_step = 12'd1;
      end
      FN_SET_US: begin
        cmd_word.tgt = q_a_r;
        cmd_word.ss_step = 12'd1;
      end
      FN_CONFIG: begin
        cmd_word.end_a = q_a_r;
        cmd_word.end_b = q_b_r;
        cmd_word.speed = (q_sp_r == '0) ? 12'd1 : q_sp_r;
        cmd_word.ss_step = 12'd1;
      end
      FN_TOGGLE: begin
        cmd_word.tgt = (rd_word.cur < mid) ? rd_word.end_b : rd_word.end_a;
        cmd_word.ss_step = 12'd1;
      end
      default: cmd_wr = 1'b0;  // query and unused codes leave state alone
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_tick_in) state_nxt = ST_TICK;
          else if (idx_ok_in && (in_ch.data.func == FN_SET_US ||
                                 in_ch.data.func == FN_CONFIG)) state_nxt = ST_DIV;
          else state_nxt = ST_MOD;
        end
      end
      ST_TICK:  if (out_free && ch_last) state_nxt = ST_IDLE;
      ST_DIV:   if (k_r == last_tag) state_nxt = ST_DWAIT;
      ST_DWAIT: if (div_rsp.valid && div_rsp.tag == last_tag) state_nxt = ST_MOD;
      ST_MOD:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req = '0;
    div_req = '0;
    out_load = 1'b0;
    out_nxt = '0;
    ch_adv = 1'b0;
    k_adv = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        mem_req.rd_en = in_acc && (is_tick_in || idx_ok_in);
        mem_req.rd_addr = is_tick_in ? '0 : CH_AW'(in_ch.data.servo_index);
      end
      ST_TICK: begin
        if (out_free) begin
          mem_req.wr_en = 1'b1;
          mem_req.wr_addr = ch_r;
          mem_req.wr_data = tick_word;
          out_load = 1'b1;
          out_nxt.kind = KIND_DRIVE;
          out_nxt.channel = 4'(ch_r);
          out_nxt.pwm_value = tick_drive;
          out_nxt.current_pos = tick_cur;
          out_nxt.target_pos = rd_word.tgt;
          out_nxt.moving = (tick_cur != rd_word.tgt);
          out_nxt.index_valid = 1'b1;
          out_nxt.last = ch_last;
          if (!ch_last) begin
            mem_req.rd_en = 1'b1;
            mem_req.rd_addr = CH_AW'(ch_r + 1'b1);
            ch_adv = 1'b1;
          end
        end
      end
      ST_DIV: begin
        div_req.valid = 1'b1;
        div_req.tag = k_r;
        k_adv = (k_r != last_tag);
        case (k_r)
          TAG_A: begin
            div_req.mode = DIV_US;
            div_req.n = us_to_n((item_r.func == FN_SET_US) ? item_r.pulse_us
                                                           : item_r.pos_a_us);
          end
          TAG_B: begin
            div_req.mode = DIV_US;
            div_req.n = us_to_n(item_r.pos_b_us);
          end
          TAG_SPEED: begin
            div_req.mode = DIV_SPEED;
            div_req.n = speed_to_n(item_r.slew_rate_us);
          end
          default: div_req.valid = 1'b0;
        endcase
      end
      ST_DWAIT: ;
      ST_MOD: begin
        if (out_free) begin
          out_load = 1'b1;
          mem_req.wr_en = cmd_wr;
          mem_req.wr_addr = CH_AW'(item_r.servo_index);
          mem_req.wr_data = cmd_word;
          out_nxt.kind = KIND_STATUS;
          out_nxt.channel = item_r.servo_index;
          out_nxt.last = 1'b1;
          if (idx_ok_r) begin
            out_nxt.current_pos = cmd_word.cur;
            out_nxt.target_pos = cmd_word.tgt;
            out_nxt.moving = (cmd_word.cur != cmd_word.tgt);
            out_nxt.index_valid = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r <= '0;
      k_r <= TAG_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) ch_r <= '0;
      else if (ch_adv) ch_r <= CH_AW'(ch_r + 1'b1);
      if (in_acc) k_r <= TAG_A;
      else if (k_adv) k_r <= div_tag_t'(k_r + 2'd1);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_ch.data;
      idx_ok_r <= idx_ok_in;
    end
    if (out_load) out_item_r <= out_nxt;
    if (div_rsp.valid) begin
      case (div_rsp.tag)
        TAG_A:     q_a_r <= div_rsp.q;
        TAG_B:     q_b_r <= div_rsp.q;
        TAG_SPEED: q_sp_r <= div_rsp.q;
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/multi_servo_slew_ramp_checker.sv =====
// Watches the command, result and register ports of the servo ramp core and checks every result.
module multi_servo_slew_ramp_checker import slw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  slw_in_if                 cmd_ch,
  slw_out_if                rpt_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count,
  output int                outstanding
);

  localparam int REPORT_LIMIT = 10;

  // shadow copy of the block's registers and per-channel state
  logic             servo_off_on;
  logic             soft_start_on;
  logic [15:0]      arrive_band;
  logic [POS_W-1:0] end_a_q  [CHANNEL_COUNT];
  logic [POS_W-1:0] end_b_q  [CHANNEL_COUNT];
  logic [POS_W-1:0] speed_q  [CHANNEL_COUNT];
  logic [POS_W-1:0] cur_q    [CHANNEL_COUNT];
  logic [POS_W-1:0] tgt_q    [CHANNEL_COUNT];
  logic [POS_W-1:0] soft_q   [CHANNEL_COUNT];

  out_item_t expected_reports[$];
  int        errors;

  function automatic logic [POS_W-1:0] us_to_counts(input logic [15:0] us);
    int v;
    v = us;
    if (v < US_MIN) v = US_MIN;
    if (v > US_MAX) v = US_MAX;
    return POS_W'((v - US_MIN) * PWM_FULL / US_RANGE);
  endfunction

  function automatic string show(input out_item_t r);
    return $sformatf("kind=%0d ch=%0d pwm=%0d cur=%0d tgt=%0d moving=%0d valid=%0d last=%0d",
                     r.kind, r.channel, r.pwm_value, r.current_pos, r.target_pos,
                     r.moving, r.index_valid, r.last);
  endfunction

  // One slew step on every channel, one drive item each.
  task automatic advance_all_channels();
    out_item_t r;
    int cur;
    int tgt;
    int gap;
    int step;
    int drive;
    for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
      cur  = cur_q[ch];
      tgt  = tgt_q[ch];
      gap  = (cur > tgt) ? cur - tgt : tgt - cur;
      if (gap <= arrive_band) begin
        cur_q[ch] = POS_W'(tgt);
        drive = servo_off_on ? 0 : tgt;
      end else begin
        step = speed_q[ch];
        if (soft_start_on) begin
          if (soft_q[ch] < step) soft_q[ch] = soft_q[ch] + 1'b1;
          step = soft_q[ch];
        end
        if (gap <= step) cur_q[ch] = POS_W'(tgt);
        else if (cur < tgt) cur_q[ch] = POS_W'(cur + step);
        else cur_q[ch] = POS_W'(cur - step);
        drive = cur_q[ch];
      end
      r.kind        = KIND_DRIVE;
      r.channel     = 4'(ch);
      r.pwm_value   = POS_W'(drive);
      r.current_pos = cur_q[ch];
      r.target_pos  = tgt_q[ch];
      r.moving      = (cur_q[ch] != tgt_q[ch]);
      r.index_valid = 1'b1;
      r.last        = (ch == CHANNEL_COUNT - 1);
      expected_reports.push_back(r);
    end
  endtask

  task automatic predict_command(input in_item_t c);
    out_item_t r;
    int ch;
    int spd;
    int mid;
    ch = c.servo_index;
    if (c.func == FN_TICK) begin
      advance_all_channels();
      return;
    end
    r.kind      = KIND_STATUS;
    r.channel   = c.servo_index;
    r.pwm_value = '0;
    r.last      = 1'b1;
    if (ch < CHANNEL_COUNT) begin
      case (c.func)
        FN_SELECT: begin
          tgt_q[ch]  = c.use_position_a ? end_a_q[ch] : end_b_q[ch];
          soft_q[ch] = 12'd1;
        end
        FN_SET_US: begin
          tgt_q[ch]  = us_to_counts(c.pulse_us);
          soft_q[ch] = 12'd1;
        end
        FN_CONFIG: begin
          spd         = int'(c.slew_rate_us) * PWM_FULL / US_RANGE / FRAMES_PER_S;
          end_a_q[ch] = us_to_counts(c.pos_a_us);
          end_b_q[ch] = us_to_counts(c.pos_b_us);
          speed_q[ch] = (spd < 1) ? POS_W'(1) : POS_W'(spd);
          soft_q[ch]  = 12'd1;
        end
        FN_TOGGLE: begin
          mid        = (int'(end_a_q[ch]) + int'(end_b_q[ch])) / 2;
          tgt_q[ch]  = (cur_q[ch] < mid) ? end_b_q[ch] : end_a_q[ch];
          soft_q[ch] = 12'd1;
        end
        default: ;  // query and spare codes leave everything alone
      endcase
      r.current_pos = cur_q[ch];
      r.target_pos  = tgt_q[ch];
      r.moving      = (cur_q[ch] != tgt_q[ch]);
      r.index_valid = 1'b1;
    end else begin
      r.current_pos = '0;
      r.target_pos  = '0;
      r.moving      = 1'b0;
      r.index_valid = 1'b0;
    end
    expected_reports.push_back(r);
  endtask

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      servo_off_on  = 1'b1;
      soft_start_on = 1'b1;
      arrive_band   = 16'd3;
      for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
        end_a_q[ch] = MID_PWM;
        end_b_q[ch] = MID_PWM;
        speed_q[ch] = SPEED_RESET;
        cur_q[ch]   = MID_PWM;
        tgt_q[ch]   = MID_PWM;
        soft_q[ch]  = 12'd1;
      end
      expected_reports.delete();
      errors = 0;
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_AW-1:2]))
          REG_SERVO_OFF:  servo_off_on  = pwdata[0];
          REG_SOFT_START: soft_start_on = pwdata[0];
          REG_DEADBAND:   arrive_band   = pwdata[15:0];
          default: ;
        endcase
      end
      if (rpt_ch.valid && rpt_ch.ready) begin
        got = rpt_ch.data;
        if (expected_reports.size() == 0) begin
          if (errors < REPORT_LIMIT) $display("unexpected result: %s", show(got));
          errors++;
        end else begin
          want = expected_reports.pop_front();
          if (got.kind !== want.kind || got.channel !== want.channel ||
              got.pwm_value !== want.pwm_value || got.current_pos !== want.current_pos ||
              got.target_pos !== want.target_pos || got.moving !== want.moving ||
              got.index_valid !== want.index_valid || got.last !== want.last) begin
            if (errors < REPORT_LIMIT) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected: %s", show(want));
              $display("  actual:   %s", show(got));
            end
            errors++;
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) predict_command(cmd_ch.data);
      fail_count  <= errors;
      outstanding <= expected_reports.size();
    end
  end

endmodule

// ===== tb/multi_servo_slew_ramp_core_test.sv =====
// Stimulus and verdict for the servo ramp core: commands, ticks, register settings and stalls.
module multi_servo_slew_ramp_core_test;
  import slw_pkg::*;

  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          IDLE_PCT      = 31;
  localparam int          PHASE_ITEMS   = 76;
  localparam int unsigned REG_UNUSED    = 3;
  localparam logic [2:0]  FN_SPARE_LO   = 3'd6;
  localparam logic [2:0]  FN_SPARE_HI   = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int outstanding;
  int cycle_count;
  bit throttle;
  bit hold_req;

  slw_in_if  cmd_if();
  slw_out_if rpt_if();

  multi_servo_slew_ramp_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (cmd_if),
    .out_ch  (rpt_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  multi_servo_slew_ramp_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_ch      (cmd_if),
    .rpt_ch      (rpt_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random back-pressure, or one long hold-off on request.
  initial begin
    rpt_if.ready <= 1'b0;
    forever begin
      if (hold_req) begin
        rpt_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        rpt_if.ready <= !(throttle && $urandom_range(99) < IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  task automatic send_cmd(input in_item_t it);
    while (throttle && $urandom_range(99) < IDLE_PCT) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  task automatic issue(input logic [2:0] fn, input logic [3:0] idx, input logic use_a,
                       input logic [15:0] pulse, input logic [15:0] pa,
                       input logic [15:0] pb, input logic [15:0] spd);
    in_item_t it;
    it.func           = fn;
    it.servo_index    = idx;
    it.use_position_a = use_a;
    it.pulse_us       = pulse;
    it.pos_a_us       = pa;
    it.pos_b_us       = pb;
    it.slew_rate_us   = spd;
    send_cmd(it);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain: stop offering, wait for every expected result, then let the core go idle.
  task automatic settle();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_us();
    if ($urandom_range(99) < 60) return 16'($urandom_range(2500, 700));
    return 16'($urandom);
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 8) it.servo_index = 4'($urandom_range(15, CHANNEL_COUNT));
    else it.servo_index = 4'($urandom_range(CHANNEL_COUNT - 1));
    it.use_position_a = 1'($urandom);
    it.pulse_us       = pick_us();
    it.pos_a_us       = pick_us();
    it.pos_b_us       = pick_us();
    // mostly slow ramps so channels take many ticks to arrive
    if ($urandom_range(99) < 70) it.slew_rate_us = 16'($urandom_range(2500));
    else it.slew_rate_us = 16'($urandom);
    if (pick < 40)      it.func = FN_TICK;
    else if (pick < 52) it.func = FN_SELECT;
    else if (pick < 64) it.func = FN_SET_US;
    else if (pick < 74) it.func = FN_CONFIG;
    else if (pick < 86) it.func = FN_TOGGLE;
    else if (pick < 94) it.func = FN_QUERY;
    else if (pick < 97) it.func = FN_SPARE_LO;
    else                it.func = FN_SPARE_HI;
    return it;
  endfunction

  task automatic run_phase(input bit off_on, input bit soft_on, input logic [15:0] band,
                           input bit quiet, input bit squeeze);
    settle();
    write_reg(REG_SERVO_OFF, {31'($urandom), off_on});
    write_reg(REG_SOFT_START, {31'($urandom), soft_on});
    write_reg(REG_DEADBAND, {16'($urandom), band});
    throttle = !quiet;
    if (squeeze) hold_req = 1'b1;
    repeat (PHASE_ITEMS) send_cmd(random_cmd());
    throttle = 1'b1;
  endtask

  initial begin
    cycle_count = 0;
    throttle    = 1'b1;
    hold_req    = 1'b0;
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, clamping, every function, invalid indexes
    issue(FN_QUERY,    4'd0,  1'b0, 16'd0,     16'd0,     16'd0,     16'd0);
    issue(FN_TICK,     4'd0,  1'b0, 16'd0,     16'd0,     16'd0,     16'd0);
    issue(FN_CONFIG,   4'd0,  1'b1, 16'hFFFF,  16'd0,     16'hFFFF,  16'hFFFF);
    issue(FN_CONFIG,   4'd1,  1'b0, 16'd0,     16'd800,   16'd2400,  16'd0);
    issue(FN_CONFIG,   4'd2,  1'b0, 16'd0,     16'd799,   16'd2401,  16'd39);
    issue(FN_SELECT,   4'd0,  1'b1, 16'd0,     16'd0,     16'd0,     16'd0);
    issue(FN_SELECT,   4'd1,  1'b0, 16'd0,     16'd0,     16'd0,     16'd0);
    issue(FN_SET_US,   4'd2,  1'b0, 16'hFFFF,  16'd0,     16'd0,     16'd0);
    issue(FN_SET_US,   4'd3,  1'b1, 16'd0,     16'hFFFF,  16'hFFFF,  16'hFFFF);
    issue(FN_SET_US,   4'd5,  1'b0, 16'd1500,  16'd0,     16'd0,     16'd0);
    // current equal to the midpoint of the ends goes to end A
    issue(FN_TOGGLE,   4'd4,  1'b0, 16'd0,     16'd0,     16'd0,     16'd0);
    issue(FN_TOGGLE,   4'd0,  1'b0, 16'd0,     16'd0,     16'd0,     16'd0);
    issue(FN_SELECT,   4'd6,  1'b1, 16'd0,     16'd0,     16'd0,     16'd0);
    issue(FN_CONFIG,   4'd15, 1'b1, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF);
    issue(FN_SPARE_LO, 4'd1,  1'b0, 16'd0,     16'd0,     16'd0,     16'd0);
    issue(FN_SPARE_HI, 4'd15, 1'b1, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF);
    issue(FN_QUERY,    4'd9,  1'b0, 16'd0,     16'd0,     16'd0,     16'd0);
    repeat (7) issue(FN_TICK, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);

    repeat (70) send_cmd(random_cmd());

    settle();
    write_reg(REG_UNUSED, $urandom);
    run_phase(1'b0, 1'b1, 16'd0, 1'b0, 1'b0);
    run_phase(1'b1, 1'b0, 16'hFFFF, 1'b0, 1'b0);
    run_phase(1'b0, 1'b0, 16'd3, 1'b1, 1'b0);
    run_phase(1'b1, 1'b1, 16'($urandom_range(40, 1)), 1'b0, 1'b1);
    run_phase(1'b0, 1'b1, 16'($urandom_range(200)), 1'b0, 1'b0);

    settle();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
